FILE: sv/word_length_char_histogram_defines.svh
// ----------------------------------------------------------------------------
// Word length / character histogram: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef WORD_LENGTH_CHAR_HISTOGRAM_DEFINES_SVH
`define WORD_LENGTH_CHAR_HISTOGRAM_DEFINES_SVH

// same-cycle implication
`define WLCH_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("wlch: implication violated");

// next-cycle implication
`define WLCH_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("wlch: next-cycle check violated");

`endif

FILE: sv/wlch_pkg.sv
// ----------------------------------------------------------------------------
// Word length / character histogram package
// Command codes, the queued operation word and the separator decode.
// ----------------------------------------------------------------------------
package wlch_pkg;

	localparam logic [1:0] CMD_FEED    = 2'd0;
	localparam logic [1:0] CMD_RD_LEN  = 2'd1;
	localparam logic [1:0] CMD_RD_CHAR = 2'd2;

	// widest table addresses the parameters allow
	localparam int CHAR_AW_MAX = 8;
	localparam int LEN_AW_MAX  = 6;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic                   char_inc;
		logic                   len_inc;
		logic                   rd;
		logic                   rd_char;
		logic                   rd_err;
		logic [CHAR_AW_MAX-1:0] char_addr;
		logic [LEN_AW_MAX-1:0]  len_addr;
	} op_t;

	// { } ( ) [ ] , ; " space newline tab ^
	function automatic logic wlch_is_sep(input logic [7:0] b);
		logic r;
		unique case (b)
			8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C,
			8'h3B, 8'h22, 8'h20, 8'h0A, 8'h09, 8'h5E: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/wlch_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wlch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/wlch_front.sv
// ----------------------------------------------------------------------------
// Histogram front end
// Classifies each word, tracks the pending token length and emits one
// operation for the back end when the word changes a counter or reads one.
// ----------------------------------------------------------------------------
module wlch_front
	import wlch_pkg::*;
#(
	parameter int LEN_BINS   = 30,
	parameter int CHAR_CODES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic       end_of_text,
	input  logic [6:0] read_index,
	output logic       push,
	output op_t        op
);

	localparam int TL_W   = $clog2(LEN_BINS + 1);
	localparam int LEN_AW = $clog2(LEN_BINS);

	logic [TL_W-1:0]   tl_q;
	logic [TL_W-1:0]   tl_d;
	logic [TL_W-1:0]   tl_inc;
	logic [TL_W-1:0]   tl_close;
	logic [LEN_AW-1:0] bin;
	logic              sep;
	logic              char_ok;

	assign sep      = wlch_is_sep(data_byte);
	assign tl_inc   = (tl_q < TL_W'(LEN_BINS)) ? tl_q + TL_W'(1) : tl_q;
	assign tl_close = sep ? tl_q : tl_inc;
	// a saturated length already sits at LEN_BINS, so length-1 is the bin
	assign bin      = LEN_AW'(tl_close - TL_W'(1));
	assign char_ok  = (data_byte >= 8'd2) && (9'(data_byte) < 9'(CHAR_CODES));

	always_comb begin
		op   = '0;
		tl_d = tl_q;
		unique case (command)
			CMD_FEED: begin
				op.char_inc  = !sep && char_ok;
				op.char_addr = data_byte[CHAR_AW_MAX-1:0];
				op.len_inc   = sep ? (tl_q != '0) : end_of_text;
				op.len_addr  = LEN_AW_MAX'(bin);
				tl_d         = (sep || end_of_text) ? '0 : tl_inc;
			end
			CMD_RD_LEN: begin
				op.rd       = 1'b1;
				op.rd_err   = 32'(read_index) >= 32'(LEN_BINS);
				op.len_addr = LEN_AW_MAX'(read_index[LEN_AW-1:0]);
			end
			CMD_RD_CHAR: begin
				op.rd        = 1'b1;
				op.rd_char   = 1'b1;
				op.rd_err    = 32'(read_index) >= 32'(CHAR_CODES);
				op.char_addr = CHAR_AW_MAX'(read_index);
			end
			default: begin
			end
		endcase
	end

	// drop words that touch nothing
	assign push = accept && (op.char_inc || op.len_inc || op.rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= '0;
		end else if (accept) begin
			tl_q <= tl_d;
		end
	end

endmodule

FILE: sv/wlch_queue.sv
// ----------------------------------------------------------------------------
// Operation queue
// Short register FIFO between the front end and the counter back end.
// ----------------------------------------------------------------------------
`include "word_length_char_histogram_defines.svh"

module wlch_queue
	import wlch_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head_op,
	output logic empty,
	output logic full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	op_t           slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(DEPTH));
	assign head_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`WLCH_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !full || pop)
	`WLCH_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, !empty)
	`WLCH_ASSERT_NEXT(a_fill_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

FILE: sv/wlch_back.sv
// ----------------------------------------------------------------------------
// Histogram back end
// Read-modify-write on the length and character counter RAMs, with a
// one-deep write bypass, reset valid bits and a registered result word.
// ----------------------------------------------------------------------------
module wlch_back
	import wlch_pkg::*;
#(
	parameter int LEN_BINS   = 30,
	parameter int CHAR_CODES = 128,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	input  op_t         op,
	output logic        op_pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] count,
	output logic        index_error
);

	localparam int LEN_AW  = $clog2(LEN_BINS);
	localparam int CHAR_AW = $clog2(CHAR_CODES);

	logic                  vld_s2;
	op_t                   op_s2;
	logic                  out_free;
	logic                  s2_go;

	logic [COUNT_BITS-1:0] char_rdata;
	logic [COUNT_BITS-1:0] len_rdata;
	logic [COUNT_BITS-1:0] char_cur;
	logic [COUNT_BITS-1:0] len_cur;
	logic [COUNT_BITS-1:0] char_nxt;
	logic [COUNT_BITS-1:0] len_nxt;
	logic [CHAR_AW-1:0]    char_a_s2;
	logic [LEN_AW-1:0]     len_a_s2;
	logic                  char_we;
	logic                  len_we;

	logic                  char_vld_q [CHAR_CODES];
	logic                  len_vld_q  [LEN_BINS];

	logic                  cw_vld_q;
	logic [CHAR_AW-1:0]    cw_addr_q;
	logic [COUNT_BITS-1:0] cw_data_q;
	logic                  lw_vld_q;
	logic [LEN_AW-1:0]     lw_addr_q;
	logic [COUNT_BITS-1:0] lw_data_q;

	logic                  out_vld_q;
	logic [31:0]           count_q;
	logic                  err_q;
	logic [COUNT_BITS-1:0] rd_val;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	assign out_free = !out_vld_q || !rsp_stall;
	// only a read can block, and only on a full result register that is stalled
	assign s2_go    = !vld_s2 || !op_s2.rd || out_free;
	assign op_pop   = s2_go && op_valid;

	wlch_ram #(.WIDTH(COUNT_BITS), .DEPTH(CHAR_CODES)) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (char_a_s2),
		.wdata (char_nxt),
		.re    (op_pop),
		.raddr (op.char_addr[CHAR_AW-1:0]),
		.rdata (char_rdata)
	);

	wlch_ram #(.WIDTH(COUNT_BITS), .DEPTH(LEN_BINS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_a_s2),
		.wdata (len_nxt),
		.re    (op_pop),
		.raddr (op.len_addr[LEN_AW-1:0]),
		.rdata (len_rdata)
	);

	assign char_a_s2 = op_s2.char_addr[CHAR_AW-1:0];
	assign len_a_s2  = op_s2.len_addr[LEN_AW-1:0];

	// the last write lands on the same edge as this read, so forward it
	assign char_cur = (cw_vld_q && cw_addr_q == char_a_s2) ? cw_data_q :
	                  (char_vld_q[char_a_s2] ? char_rdata : '0);
	assign len_cur  = (lw_vld_q && lw_addr_q == len_a_s2) ? lw_data_q :
	                  (len_vld_q[len_a_s2] ? len_rdata : '0);
	assign char_nxt = sat_inc(char_cur);
	assign len_nxt  = sat_inc(len_cur);
	assign char_we  = vld_s2 && s2_go && op_s2.char_inc;
	assign len_we   = vld_s2 && s2_go && op_s2.len_inc;

	assign rd_val   = op_s2.rd_err ? '0 : (op_s2.rd_char ? char_cur : len_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			cw_vld_q  <= 1'b0;
			lw_vld_q  <= 1'b0;
			for (int i = 0; i < CHAR_CODES; i++) begin
				char_vld_q[i] <= 1'b0;
			end
			for (int i = 0; i < LEN_BINS; i++) begin
				len_vld_q[i] <= 1'b0;
			end
		end else begin
			if (s2_go) begin
				vld_s2 <= op_valid;
			end
			if (char_we) begin
				char_vld_q[char_a_s2] <= 1'b1;
				cw_vld_q              <= 1'b1;
			end
			if (len_we) begin
				len_vld_q[len_a_s2] <= 1'b1;
				lw_vld_q            <= 1'b1;
			end
			if (vld_s2 && op_s2.rd && out_free) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_s2 <= op;
		end
		if (char_we) begin
			cw_addr_q <= char_a_s2;
			cw_data_q <= char_nxt;
		end
		if (len_we) begin
			lw_addr_q <= len_a_s2;
			lw_data_q <= len_nxt;
		end
		if (vld_s2 && op_s2.rd && out_free) begin
			count_q <= clip32(rd_val);
			err_q   <= op_s2.rd_err;
		end
	end

	assign rsp_valid   = out_vld_q;
	assign count       = count_q;
	assign index_error = err_q;

endmodule

FILE: sv/word_length_char_histogram.sv
// Reads: a read result reaches rsp_valid through the queue, stage-2 and result
// registers; feed words produce no result. Throughput: one word per cycle while
// cmd_stall is low; the counter RAM read-modify-write runs at one operation per
// cycle with a one-deep write bypass while no read waits on a stalled result.
// Reset: all counters read as zero right after arst_n; per-entry valid bits
// clear at once, so no clearing pass is needed and words are taken at once.
// ----------------------------------------------------------------------------
// Word length and character histogram, top level
// Front end classifies text bytes and commands, a short queue decouples it
// from the back end that updates and reads the counter RAMs.
// ----------------------------------------------------------------------------
module word_length_char_histogram
	import wlch_pkg::*;
#(
	parameter int LEN_BINS   = 30,
	parameter int CHAR_CODES = 128,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	input  logic [6:0]  read_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] count,
	output logic        index_error
);

	logic accept;
	logic push;
	op_t  push_op;
	op_t  head_op;
	logic q_empty;
	logic q_full;
	logic pop;

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !cmd_stall;

	wlch_front #(.LEN_BINS(LEN_BINS), .CHAR_CODES(CHAR_CODES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.read_index  (read_index),
		.push        (push),
		.op          (push_op)
	);

	wlch_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty),
		.full    (q_full)
	);

	wlch_back #(
		.LEN_BINS   (LEN_BINS),
		.CHAR_CODES (CHAR_CODES),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (!q_empty),
		.op          (head_op),
		.op_pop      (pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.count       (count),
		.index_error (index_error)
	);

endmodule

FILE: bench/histogram_checker.sv
// ----------------------------------------------------------------------------
// Word length / character histogram checker
// Watches the command and response channels, keeps its own copy of the token
// length, length bins and character counts, and compares every read response
// against the oldest read still waiting for its result.
// ----------------------------------------------------------------------------
module histogram_checker
	import wlch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	input  logic [6:0]  read_index,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [31:0] count,
	input  logic        index_error,
	output int          mismatches,
	output int          reads_due
);

	localparam int LEN_BINS   = 30;
	localparam int CHAR_CODES = 128;

	logic [4:0]  run_len;
	logic [31:0] len_hist  [LEN_BINS];
	logic [31:0] char_hist [CHAR_CODES];
	logic [31:0] count_due [$];
	logic        error_due [$];

	// { } ( ) [ ] , ; " space newline tab ^
	function automatic logic is_break(input logic [7:0] b);
		case (b)
			8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C,
			8'h3B, 8'h22, 8'h20, 8'h0A, 8'h09, 8'h5E: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// run_len saturates at LEN_BINS, so long tokens land in the last bin
	function automatic void end_token();
		if (run_len != 5'd0) begin
			if (len_hist[run_len - 5'd1] != '1)
				len_hist[run_len - 5'd1] = len_hist[run_len - 5'd1] + 32'd1;
			run_len = 5'd0;
		end
	endfunction

	function automatic void flag(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("histogram mismatch: %s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want_count;
		logic        want_error;
		if (!arst_n) begin
			run_len = 5'd0;
			for (int i = 0; i < LEN_BINS; i++)
				len_hist[i] = '0;
			for (int i = 0; i < CHAR_CODES; i++)
				char_hist[i] = '0;
			count_due.delete();
			error_due.delete();
			reads_due = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (count_due.size() == 0) begin
					flag($sformatf("response with no read pending: count %0d, index_error %0b",
						count, index_error));
				end else begin
					want_count = count_due.pop_front();
					want_error = error_due.pop_front();
					if (count !== want_count)
						flag($sformatf("count: expected %0d, got %0d", want_count, count));
					if (index_error !== want_error)
						flag($sformatf("index_error: expected %0b, got %0b",
							want_error, index_error));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				case (command)
					CMD_FEED: begin
						if (is_break(data_byte)) begin
							end_token();
						end else begin
							if (run_len < LEN_BINS)
								run_len = run_len + 5'd1;
							// codes 0 and 1 and the upper half lengthen the token only
							if (data_byte >= 8'd2 && data_byte < CHAR_CODES &&
									char_hist[data_byte[6:0]] != '1)
								char_hist[data_byte[6:0]] = char_hist[data_byte[6:0]] + 32'd1;
						end
						if (end_of_text)
							end_token();
					end
					CMD_RD_LEN: begin
						if (read_index < LEN_BINS) begin
							count_due.push_back(len_hist[read_index[4:0]]);
							error_due.push_back(1'b0);
						end else begin
							count_due.push_back('0);
							error_due.push_back(1'b1);
						end
					end
					CMD_RD_CHAR: begin
						// a 7-bit index always falls inside the character table
						count_due.push_back(char_hist[read_index]);
						error_due.push_back(1'b0);
					end
					default: ;
				endcase
			end
			reads_due = count_due.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Word length / character histogram testbench
// Feeds directed and random text and read words through the command channel
// under three idling mixes and one long response hold-off, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
	import wlch_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int STAGE1_END     = 380;
	localparam int STAGE2_END     = 760;
	localparam int WORD_TARGET    = 1100;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cmd_valid   = 1'b0;
	logic [1:0]  command     = CMD_FEED;
	logic [7:0]  data_byte   = 8'h00;
	logic        end_of_text = 1'b0;
	logic [6:0]  read_index  = 7'd0;
	logic        rsp_stall   = 1'b0;
	logic        cmd_stall;
	logic        rsp_valid;
	logic [31:0] count;
	logic        index_error;

	int mismatches;
	int reads_due;
	int words_sent     = 0;
	int stage          = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	logic [7:0] break_bytes [13] = '{8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2C,
		8'h3B, 8'h22, 8'h20, 8'h0A, 8'h09, 8'h5E};

	always #5 clk = ~clk;

	word_length_char_histogram uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.read_index  (read_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.count       (count),
		.index_error (index_error)
	);

	histogram_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.read_index  (read_index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.count       (count),
		.index_error (index_error),
		.mismatches  (mismatches),
		.reads_due   (reads_due)
	);

	// Enter at a falling edge, leave at the falling edge after acceptance.
	task automatic send_word(input logic [1:0] c, input logic [7:0] b, input logic e,
			input logic [6:0] i);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid   <= 1'b1;
		command     <= c;
		data_byte   <= b;
		end_of_text <= e;
		read_index  <= i;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
		if (c != CMD_SPARE)
			words_sent++;
	endtask

	// One token with up to two trailing separators, one read, or one word of noise.
	task automatic send_text_stretch();
		int         r;
		int         len;
		logic [7:0] b;
		logic       eot;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
		end else if (r < 35) begin
			if ($urandom_range(0, 1))
				send_word(CMD_RD_LEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
						: $urandom_range(0, 29)));
			else
				send_word(CMD_RD_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					7'($urandom_range(0, 1) ? 32'h61 + $urandom_range(0, 7)
						: $urandom_range(0, 127)));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 80)
				len = $urandom_range(1, 8);
			else if (r < 92)
				len = $urandom_range(9, 20);
			else
				len = $urandom_range(25, 40);
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					b = 8'(32'h61 + $urandom_range(0, 7));
				else if (r < 70)
					b = 8'($urandom_range(0, 1));
				else
					b = 8'($urandom_range(0, 255));
				while (wlch_is_sep(b))
					b = 8'($urandom_range(0, 255));
				eot = (k == len - 1) && ($urandom_range(0, 9) == 0);
				send_word(CMD_FEED, b, eot, 7'($urandom_range(0, 127)));
			end
			repeat ($urandom_range(0, 2))
				send_word(CMD_FEED, break_bytes[4'($urandom_range(0, 12))],
					1'($urandom_range(0, 19) == 0), 7'($urandom_range(0, 127)));
		end
	endtask

	// response side: random stall, plus one long hold-off when stage 3 opens
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (stage == 3 && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		stage          = 1;
		send_idle_pct  = 6;
		recv_stall_pct = 71;

		// empty tables, both table edges and indexes past the length table
		send_word(CMD_RD_LEN, 8'h00, 1'b0, 7'd0);
		send_word(CMD_RD_LEN, 8'hFF, 1'b0, 7'd29);
		send_word(CMD_RD_LEN, 8'h00, 1'b0, 7'd30);
		send_word(CMD_RD_LEN, 8'h00, 1'b0, 7'd127);
		send_word(CMD_RD_CHAR, 8'h00, 1'b0, 7'd127);
		// token "a", 00, 01, FF, 7F: uncounted codes still add to its length
		send_word(CMD_FEED, 8'h61, 1'b0, 7'd0);
		send_word(CMD_FEED, 8'h00, 1'b0, 7'd0);
		send_word(CMD_FEED, 8'h01, 1'b0, 7'd0);
		send_word(CMD_FEED, 8'hFF, 1'b0, 7'd0);
		// spare command with a separator and end of text: must change nothing
		send_word(CMD_SPARE, 8'h20, 1'b1, 7'd127);
		// end of text on a read must not close the pending token
		send_word(CMD_RD_LEN, 8'h00, 1'b1, 7'd3);
		send_word(CMD_FEED, 8'h7F, 1'b0, 7'd0);
		send_word(CMD_FEED, 8'h20, 1'b0, 7'd0);
		// empty token between two separators
		send_word(CMD_FEED, 8'h28, 1'b0, 7'd0);
		// end of text closes a one-byte token, then closes nothing
		send_word(CMD_FEED, 8'h7A, 1'b1, 7'd0);
		send_word(CMD_FEED, 8'h0A, 1'b1, 7'd0);
		send_word(CMD_RD_LEN, 8'h00, 1'b0, 7'd0);
		send_word(CMD_RD_LEN, 8'h00, 1'b0, 7'd4);
		send_word(CMD_RD_CHAR, 8'h00, 1'b0, 7'h61);
		send_word(CMD_RD_CHAR, 8'h00, 1'b0, 7'h00);
		send_word(CMD_RD_CHAR, 8'h00, 1'b0, 7'h01);
		send_word(CMD_RD_CHAR, 8'h00, 1'b0, 7'h7F);
		send_word(CMD_RD_CHAR, 8'h00, 1'b0, 7'h7A);

		while (words_sent < STAGE1_END)
			send_text_stretch();

		stage          = 2;
		send_idle_pct  = 71;
		recv_stall_pct = 6;
		while (words_sent < STAGE2_END)
			send_text_stretch();

		stage          = 3;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (words_sent < WORD_TARGET)
			send_text_stretch();

		cmd_valid <= 1'b0;
		wait (reads_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
